>>> rtl/text_console_cursor_scroll_unit_macros.svh
// ----------------------------------------------------------------------------
// text console assertion macros
// concurrent checks, left out of synthesis builds
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_UNIT_MACROS_SVH

`ifndef SYNTH

`define TCCS_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("text console check failed");

`define TCCS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("text console check failed");

`else

`define TCCS_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define TCCS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// text console package
// item kinds, character codes and cell constants
// ----------------------------------------------------------------------------
package tccs_pkg;

  typedef logic [1:0]  kind_t;
  typedef logic [7:0]  byte_t;
  typedef logic [15:0] cell_t;

  localparam kind_t KIND_PUT   = 2'd0;
  localparam kind_t KIND_WRITE = 2'd1;
  localparam kind_t KIND_READ  = 2'd2;

  localparam byte_t NEWLINE_CHAR = 8'd10;
  localparam byte_t SPACE_CHAR   = 8'd32;
  localparam byte_t RESET_COLOR  = 8'd7;

  localparam cell_t RESET_CELL = {RESET_COLOR, SPACE_CHAR};

endpackage

>>> rtl/tccs_ram.sv
// ----------------------------------------------------------------------------
// generic ram
// one write port, one read port, read data registered
// ----------------------------------------------------------------------------
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/text_console_cursor_scroll_unit.sv
// ----------------------------------------------------------------------------
// text console cursor and scroll unit
// put, write and unused items pass ST_EXEC before done; reads pass ST_EXEC
// and ST_RDWAIT. the next item is taken at the edge that takes done.
// a put that passes the bottom row scrolls,
// one cell a cycle through the store's one read port and one write port.
// after reset the store is cleared one cell a cycle (busy high); done
// cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`include "text_console_cursor_scroll_unit_macros.svh"

module text_console_cursor_scroll_unit
  import tccs_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        text_color_we,
  input  logic [7:0]  text_color,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [7:0]  character,
  input  logic [7:0]  cell_color,
  input  logic [6:0]  target_column,
  input  logic [4:0]  target_row,
  output logic        done,
  output logic [15:0] cell_entry,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_column
);

  localparam int TOTAL  = COLUMNS * ROWS;
  localparam int COPY_N = COLUMNS * (ROWS - 1);
  localparam int AW     = $clog2(TOTAL);
  localparam int CW     = $clog2(TOTAL + 1);
  localparam int RW     = $clog2(ROWS);
  localparam int CLW    = $clog2(COLUMNS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_RDWAIT = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_CLEAR  = 3'd4;

  logic [2:0]     state, state_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic           stg_valid, stg_valid_next;
  logic           stg_copy, stg_copy_next;
  logic [AW-1:0]  stg_idx, stg_idx_next;
  logic [RW-1:0]  crow, crow_next;
  logic [CLW-1:0] ccol, ccol_next;
  logic [7:0]     color;
  logic           rd_ok, rd_ok_next;

  kind_t      kind_q;
  logic [7:0] char_q;
  logic [7:0] ccolor_q;
  logic [6:0] tcol_q;
  logic [4:0] trow_q;

  logic        done_next;
  logic [15:0] entry_next;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  cell_t         wdata, rdata;

  logic          on_screen;
  logic [AW-1:0] target_addr, cursor_addr;
  logic          last_col, last_row;

  assign busy = (state != ST_IDLE);

  assign on_screen   = (32'(tcol_q) < COLUMNS) && (32'(trow_q) < ROWS);
  assign target_addr = AW'(32'(trow_q) * COLUMNS + 32'(tcol_q));
  assign cursor_addr = AW'(32'(crow) * COLUMNS + 32'(ccol));
  assign last_col    = (32'(ccol) == COLUMNS - 1);
  assign last_row    = (32'(crow) == ROWS - 1);

  tccs_ram #(
    .WIDTH (16),
    .DEPTH (TOTAL)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    stg_valid_next = 1'b0;
    stg_copy_next  = stg_copy;
    stg_idx_next   = stg_idx;
    crow_next      = crow;
    ccol_next      = ccol;
    rd_ok_next     = rd_ok;
    done_next      = 1'b0;
    entry_next     = 16'h0;
    we             = 1'b0;
    waddr          = cursor_addr;
    wdata          = {color, char_q};
    re             = 1'b0;
    raddr          = target_addr;

    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        state_next = ST_IDLE;
        done_next  = 1'b1;
        case (kind_q)
          KIND_PUT: begin
            if (char_q == NEWLINE_CHAR || last_col) begin
              ccol_next = '0;
              if (last_row) begin
                // bottom passed: cursor stays on the last row
                state_next = ST_SCROLL;
                done_next  = 1'b0;
                cnt_next   = '0;
              end else begin
                crow_next = crow + RW'(1);
              end
            end else begin
              ccol_next = ccol + CLW'(1);
            end
            if (char_q != NEWLINE_CHAR) begin
              we = 1'b1;
            end
          end
          KIND_WRITE: begin
            we    = on_screen;
            waddr = target_addr;
            wdata = {ccolor_q, char_q};
          end
          KIND_READ: begin
            re         = on_screen;
            rd_ok_next = on_screen;
            state_next = ST_RDWAIT;
            done_next  = 1'b0;
          end
          default: begin
          end
        endcase
      end

      ST_RDWAIT: begin
        state_next = ST_IDLE;
        done_next  = 1'b1;
        entry_next = rd_ok ? rdata : 16'h0;
      end

      ST_SCROLL: begin
        // read a row below, write one stage later
        if (32'(cnt) < TOTAL) begin
          re             = (32'(cnt) < COPY_N);
          raddr          = AW'(32'(cnt) + COLUMNS);
          stg_valid_next = 1'b1;
          stg_idx_next   = AW'(cnt);
          stg_copy_next  = (32'(cnt) < COPY_N);
          cnt_next       = cnt + CW'(1);
        end
        if (stg_valid) begin
          we    = 1'b1;
          waddr = stg_idx;
          wdata = stg_copy ? rdata : {color, SPACE_CHAR};
          if (32'(stg_idx) == TOTAL - 1) begin
            state_next = ST_IDLE;
            done_next  = 1'b1;
          end
        end
      end

      ST_CLEAR: begin
        we       = 1'b1;
        waddr    = AW'(cnt);
        wdata    = RESET_CELL;
        cnt_next = cnt + CW'(1);
        if (32'(cnt) == TOTAL - 1) begin
          state_next = ST_IDLE;
          cnt_next   = '0;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      stg_valid <= 1'b0;
      crow      <= '0;
      ccol      <= '0;
      color     <= RESET_COLOR;
      done      <= 1'b0;
      rd_ok     <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      stg_valid <= stg_valid_next;
      crow      <= crow_next;
      ccol      <= ccol_next;
      rd_ok     <= rd_ok_next;
      done      <= done_next;
      if (text_color_we) begin
        color <= text_color;
      end
    end
  end

  always_ff @(posedge clk) begin
    stg_copy <= stg_copy_next;
    stg_idx  <= stg_idx_next;
    if (state == ST_IDLE && start) begin
      kind_q   <= kind;
      char_q   <= character;
      ccolor_q <= cell_color;
      tcol_q   <= target_column;
      trow_q   <= target_row;
    end
    if (done_next) begin
      cell_entry    <= entry_next;
      cursor_row    <= 5'(crow_next);
      cursor_column <= 7'(ccol_next);
    end
  end

  `TCCS_ASSERT_IMPLIES(a_done_idle, clk, rst, done, state == ST_IDLE)
  `TCCS_ASSERT_ALWAYS(a_row_range, clk, rst, 32'(crow) < ROWS)
  `TCCS_ASSERT_ALWAYS(a_col_range, clk, rst, 32'(ccol) < COLUMNS)
  `TCCS_ASSERT_IMPLIES(a_entry_zero, clk, rst, done && kind_q != KIND_READ, cell_entry == 16'h0)
  `TCCS_ASSERT_IMPLIES(a_clear_quiet, clk, rst, state == ST_CLEAR, !done && !re)

endmodule
